/* rtl/erpt_pkg.sv */
// ---------------------------------------------------------------------------
// erpt_pkg: shared types and constants of the rigid point transform
// Register indexes, coefficient term descriptors, the arctangent table and
// helpers used by the rebuild sequencer and the CORDIC lanes.
// ---------------------------------------------------------------------------
package erpt_pkg;

  // configuration register indexes
  localparam logic [3:0] REG_ROLL  = 4'd0;
  localparam logic [3:0] REG_PITCH = 4'd1;
  localparam logic [3:0] REG_YAW   = 4'd2;
  localparam logic [3:0] REG_THIRD = 4'd3;
  localparam logic [3:0] REG_SHX   = 4'd4;
  localparam logic [3:0] REG_SHY   = 4'd5;
  localparam logic [3:0] REG_SHZ   = 4'd6;
  localparam logic [3:0] REG_MODE  = 4'd7;

  localparam logic [5:0] MODE_RESET = 6'd7;

  // axis order codes (mode bits 3..0)
  localparam logic [3:0] ORD_RYR = 4'd0;
  localparam logic [3:0] ORD_RPR = 4'd1;
  localparam logic [3:0] ORD_PRP = 4'd2;
  localparam logic [3:0] ORD_PYP = 4'd3;
  localparam logic [3:0] ORD_YPY = 4'd4;
  localparam logic [3:0] ORD_YRY = 4'd5;
  localparam logic [3:0] ORD_RYP = 4'd6;
  localparam logic [3:0] ORD_RPY = 4'd7;
  localparam logic [3:0] ORD_PRY = 4'd8;
  localparam logic [3:0] ORD_PYR = 4'd9;
  localparam logic [3:0] ORD_YPR = 4'd10;
  localparam logic [3:0] ORD_YRP = 4'd11;
  localparam logic [3:0] ORD_IDENT = 4'd15;

  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;
  localparam logic signed [39:0] C18_MAX = 40'sd131071;
  localparam logic signed [39:0] C18_MIN = -40'sd131072;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {SG_ZERO, SG_POS, SG_NEG} sign_e;

  // trig operand codes; the code is the index into the operand table
  typedef enum logic [3:0] {
    OP_ONE, OP_CR, OP_SR, OP_CP, OP_SP, OP_CY, OP_SY, OP_CT, OP_ST
  } opnd_e;

  // one term: sign * rnd(rnd(a*b)*c)
  typedef struct packed {
    sign_e sg;
    opnd_e a;
    opnd_e b;
    opnd_e c;
  } term_t;

  typedef struct packed {
    term_t t0;
    term_t t1;
  } entry_t;

  function automatic logic signed [17:0] sat18(input logic signed [39:0] v);
    logic signed [17:0] r;
    if (v > C18_MAX) r = 18'sd131071;
    else if (v < C18_MIN) r = -18'sd131072;
    else r = v[17:0];
    return r;
  endfunction

  function automatic term_t a3(input opnd_e a, input opnd_e b, input opnd_e c);
    return '{SG_POS, a, b, c};
  endfunction
  function automatic term_t s3(input opnd_e a, input opnd_e b, input opnd_e c);
    return '{SG_NEG, a, b, c};
  endfunction
  function automatic term_t a2(input opnd_e a, input opnd_e b);
    return '{SG_POS, a, b, OP_ONE};
  endfunction
  function automatic term_t s2(input opnd_e a, input opnd_e b);
    return '{SG_NEG, a, b, OP_ONE};
  endfunction
  function automatic term_t a1(input opnd_e a);
    return '{SG_POS, a, OP_ONE, OP_ONE};
  endfunction
  function automatic term_t s1(input opnd_e a);
    return '{SG_NEG, a, OP_ONE, OP_ONE};
  endfunction
  function automatic term_t tz();
    return '{SG_ZERO, OP_ONE, OP_ONE, OP_ONE};
  endfunction

  // matrix entry ent (row major) of the rotation in axis order ord
  function automatic entry_t coef_term(input logic [3:0] ord, input logic [3:0] ent);
    entry_t r;
    r = '{tz(), tz()};
    case (ord)
      ORD_RYR: case (ent)
        4'd0: r = '{a1(OP_CY), tz()};
        4'd1: r = '{s2(OP_CT, OP_SY), tz()};
        4'd2: r = '{a2(OP_SY, OP_ST), tz()};
        4'd3: r = '{a2(OP_CR, OP_SY), tz()};
        4'd4: r = '{a3(OP_CR, OP_CY, OP_CT), s2(OP_SR, OP_ST)};
        4'd5: r = '{s2(OP_CT, OP_SR), s3(OP_CR, OP_CY, OP_ST)};
        4'd6: r = '{a2(OP_SR, OP_SY), tz()};
        4'd7: r = '{a2(OP_CR, OP_ST), a3(OP_CY, OP_CT, OP_SR)};
        4'd8: r = '{a2(OP_CR, OP_CT), s3(OP_CY, OP_SR, OP_ST)};
        default: r = '{tz(), tz()};
      endcase
      ORD_RPR: case (ent)
        4'd0: r = '{a1(OP_CP), tz()};
        4'd1: r = '{a2(OP_SP, OP_ST), tz()};
        4'd2: r = '{a2(OP_CT, OP_SP), tz()};
        4'd3: r = '{a2(OP_SR, OP_SP), tz()};
        4'd4: r = '{a2(OP_CR, OP_CT), s3(OP_CP, OP_SR, OP_ST)};
        4'd5: r = '{s2(OP_CR, OP_ST), s3(OP_CP, OP_CT, OP_SR)};
        4'd6: r = '{s2(OP_CR, OP_SP), tz()};
        4'd7: r = '{a2(OP_CT, OP_SR), a3(OP_CR, OP_CP, OP_ST)};
        4'd8: r = '{a3(OP_CR, OP_CP, OP_CT), s2(OP_SR, OP_ST)};
        default: r = '{tz(), tz()};
      endcase
      ORD_PRP: case (ent)
        4'd0: r = '{a2(OP_CP, OP_CT), s3(OP_CR, OP_SP, OP_ST)};
        4'd1: r = '{a2(OP_SP, OP_SR), tz()};
        4'd2: r = '{a2(OP_CP, OP_ST), a3(OP_CR, OP_CT, OP_SP)};
        4'd3: r = '{a2(OP_SR, OP_ST), tz()};
        4'd4: r = '{a1(OP_CR), tz()};
        4'd5: r = '{s2(OP_CT, OP_SR), tz()};
        4'd6: r = '{s2(OP_CT, OP_SP), s3(OP_CP, OP_CR, OP_ST)};
        4'd7: r = '{a2(OP_CP, OP_SR), tz()};
        4'd8: r = '{a3(OP_CP, OP_CR, OP_CT), s2(OP_SP, OP_ST)};
        default: r = '{tz(), tz()};
      endcase
      ORD_PYP: case (ent)
        4'd0: r = '{a3(OP_CP, OP_CY, OP_CT), s2(OP_SP, OP_ST)};
        4'd1: r = '{s2(OP_CP, OP_SY), tz()};
        4'd2: r = '{a2(OP_CT, OP_SP), a3(OP_CP, OP_CY, OP_ST)};
        4'd3: r = '{a2(OP_CT, OP_SY), tz()};
        4'd4: r = '{a1(OP_CY), tz()};
        4'd5: r = '{a2(OP_SY, OP_ST), tz()};
        4'd6: r = '{s2(OP_CP, OP_ST), s3(OP_CY, OP_CT, OP_SP)};
        4'd7: r = '{a2(OP_SP, OP_SY), tz()};
        4'd8: r = '{a2(OP_CP, OP_CT), s3(OP_CY, OP_SP, OP_ST)};
        default: r = '{tz(), tz()};
      endcase
      ORD_YPY: case (ent)
        4'd0: r = '{a3(OP_CY, OP_CP, OP_CT), s2(OP_SY, OP_ST)};
        4'd1: r = '{s2(OP_CT, OP_SY), s3(OP_CY, OP_CP, OP_ST)};
        4'd2: r = '{a2(OP_CY, OP_SP), tz()};
        4'd3: r = '{a2(OP_CY, OP_ST), a3(OP_CP, OP_CT, OP_SY)};
        4'd4: r = '{a2(OP_CY, OP_CT), s3(OP_CP, OP_SY, OP_ST)};
        4'd5: r = '{a2(OP_SY, OP_SP), tz()};
        4'd6: r = '{s2(OP_CT, OP_SP), tz()};
        4'd7: r = '{a2(OP_SP, OP_ST), tz()};
        4'd8: r = '{a1(OP_CP), tz()};
        default: r = '{tz(), tz()};
      endcase
      ORD_YRY: case (ent)
        4'd0: r = '{a2(OP_CY, OP_CT), s3(OP_CR, OP_SY, OP_ST)};
        4'd1: r = '{s2(OP_CY, OP_ST), s3(OP_CR, OP_CT, OP_SY)};
        4'd2: r = '{a2(OP_SY, OP_SR), tz()};
        4'd3: r = '{a2(OP_CT, OP_SY), a3(OP_CY, OP_CR, OP_ST)};
        4'd4: r = '{a3(OP_CY, OP_CR, OP_CT), s2(OP_SY, OP_ST)};
        4'd5: r = '{s2(OP_CY, OP_SR), tz()};
        4'd6: r = '{a2(OP_SR, OP_ST), tz()};
        4'd7: r = '{a2(OP_CT, OP_SR), tz()};
        4'd8: r = '{a1(OP_CR), tz()};
        default: r = '{tz(), tz()};
      endcase
      ORD_RYP: case (ent)
        4'd0: r = '{a2(OP_CY, OP_CP), tz()};
        4'd1: r = '{s1(OP_SY), tz()};
        4'd2: r = '{a2(OP_CY, OP_SP), tz()};
        4'd3: r = '{a2(OP_SR, OP_SP), a3(OP_CR, OP_CP, OP_SY)};
        4'd4: r = '{a2(OP_CR, OP_CY), tz()};
        4'd5: r = '{a3(OP_CR, OP_SY, OP_SP), s2(OP_CP, OP_SR)};
        4'd6: r = '{a3(OP_CP, OP_SR, OP_SY), s2(OP_CR, OP_SP)};
        4'd7: r = '{a2(OP_CY, OP_SR), tz()};
        4'd8: r = '{a2(OP_CR, OP_CP), a3(OP_SR, OP_SY, OP_SP)};
        default: r = '{tz(), tz()};
      endcase
      ORD_RPY: case (ent)
        4'd0: r = '{a2(OP_CP, OP_CY), tz()};
        4'd1: r = '{s2(OP_CP, OP_SY), tz()};
        4'd2: r = '{a1(OP_SP), tz()};
        4'd3: r = '{a2(OP_CR, OP_SY), a3(OP_CY, OP_SR, OP_SP)};
        4'd4: r = '{a2(OP_CR, OP_CY), s3(OP_SR, OP_SP, OP_SY)};
        4'd5: r = '{s2(OP_CP, OP_SR), tz()};
        4'd6: r = '{a2(OP_SR, OP_SY), s3(OP_CR, OP_CY, OP_SP)};
        4'd7: r = '{a2(OP_CY, OP_SR), a3(OP_CR, OP_SP, OP_SY)};
        4'd8: r = '{a2(OP_CR, OP_CP), tz()};
        default: r = '{tz(), tz()};
      endcase
      ORD_PRY: case (ent)
        4'd0: r = '{a2(OP_CP, OP_CY), a3(OP_SP, OP_SR, OP_SY)};
        4'd1: r = '{a3(OP_CY, OP_SP, OP_SR), s2(OP_CP, OP_SY)};
        4'd2: r = '{a2(OP_CR, OP_SP), tz()};
        4'd3: r = '{a2(OP_CR, OP_SY), tz()};
        4'd4: r = '{a2(OP_CR, OP_CY), tz()};
        4'd5: r = '{s1(OP_SR), tz()};
        4'd6: r = '{a3(OP_CP, OP_SR, OP_SY), s2(OP_CY, OP_SP)};
        4'd7: r = '{a3(OP_CP, OP_CY, OP_SR), a2(OP_SP, OP_SY)};
        4'd8: r = '{a2(OP_CP, OP_CR), tz()};
        default: r = '{tz(), tz()};
      endcase
      ORD_PYR: case (ent)
        4'd0: r = '{a2(OP_CP, OP_CY), tz()};
        4'd1: r = '{a2(OP_SP, OP_SR), s3(OP_CP, OP_CR, OP_SY)};
        4'd2: r = '{a2(OP_CR, OP_SP), a3(OP_CP, OP_SY, OP_SR)};
        4'd3: r = '{a1(OP_SY), tz()};
        4'd4: r = '{a2(OP_CY, OP_CR), tz()};
        4'd5: r = '{s2(OP_CY, OP_SR), tz()};
        4'd6: r = '{s2(OP_CY, OP_SP), tz()};
        4'd7: r = '{a2(OP_CP, OP_SR), a3(OP_CR, OP_SP, OP_SY)};
        4'd8: r = '{a2(OP_CP, OP_CR), s3(OP_SP, OP_SY, OP_SR)};
        default: r = '{tz(), tz()};
      endcase
      ORD_YPR: case (ent)
        4'd0: r = '{a2(OP_CY, OP_CP), tz()};
        4'd1: r = '{a3(OP_CY, OP_SP, OP_SR), s2(OP_CR, OP_SY)};
        4'd2: r = '{a2(OP_SY, OP_SR), a3(OP_CY, OP_CR, OP_SP)};
        4'd3: r = '{a2(OP_CP, OP_SY), tz()};
        4'd4: r = '{a2(OP_CY, OP_CR), a3(OP_SY, OP_SP, OP_SR)};
        4'd5: r = '{a3(OP_CR, OP_SY, OP_SP), s2(OP_CY, OP_SR)};
        4'd6: r = '{s1(OP_SP), tz()};
        4'd7: r = '{a2(OP_CP, OP_SR), tz()};
        4'd8: r = '{a2(OP_CP, OP_CR), tz()};
        default: r = '{tz(), tz()};
      endcase
      ORD_YRP: case (ent)
        4'd0: r = '{a2(OP_CY, OP_CP), s3(OP_SY, OP_SR, OP_SP)};
        4'd1: r = '{s2(OP_CR, OP_SY), tz()};
        4'd2: r = '{a2(OP_CY, OP_SP), a3(OP_CP, OP_SY, OP_SR)};
        4'd3: r = '{a2(OP_CP, OP_SY), a3(OP_CY, OP_SR, OP_SP)};
        4'd4: r = '{a2(OP_CY, OP_CR), tz()};
        4'd5: r = '{a2(OP_SY, OP_SP), s3(OP_CY, OP_CP, OP_SR)};
        4'd6: r = '{s2(OP_CR, OP_SP), tz()};
        4'd7: r = '{a1(OP_SR), tz()};
        4'd8: r = '{a2(OP_CR, OP_CP), tz()};
        default: r = '{tz(), tz()};
      endcase
      default: begin
        // identity for the world frame and unused order codes
        if (ent == 4'd0 || ent == 4'd4 || ent == 4'd8) r = '{a1(OP_ONE), tz()};
        else r = '{tz(), tz()};
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/erpt_in_if.sv */
// ---------------------------------------------------------------------------
// erpt_in_if: input point channel
// Valid/ready channel carrying one 3-D point per transaction.
// ---------------------------------------------------------------------------
interface erpt_in_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic signed [COORD_BITS-1:0] in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

/* rtl/erpt_out_if.sv */
// ---------------------------------------------------------------------------
// erpt_out_if: output point channel
// Valid/ready channel carrying one transformed point per transaction.
// ---------------------------------------------------------------------------
interface erpt_out_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

/* rtl/erpt_cordic.sv */
// ---------------------------------------------------------------------------
// erpt_cordic: iterative sine/cosine lane
// One CORDIC micro-rotation per cycle, quadrant folding, Q16 rounding.
// ---------------------------------------------------------------------------
module erpt_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int STAGES     = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ANGLE_BITS-1:0]  angle_i,
  output logic                   done_o,
  output logic signed [17:0]     cos_o,
  output logic signed [17:0]     sin_o
);
  localparam int IW = $clog2(STAGES);

  logic               busy_q, done_q, flip_q;
  logic [IW-1:0]      i_q;
  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;

  logic [31:0]        ph;
  logic               flip;
  logic signed [32:0] z0;
  logic signed [33:0] dx, dy, xr, yr;
  logic signed [32:0] at;

  assign ph   = {angle_i, {(32 - ANGLE_BITS){1'b0}}};
  assign flip = ph[31] ^ ph[30];
  assign z0   = 33'(signed'({ph[31] ^ flip, ph[30:0]}));
  assign dx   = y_q >>> i_q;
  assign dy   = x_q >>> i_q;
  assign at   = signed'({1'b0, erpt_pkg::ATAN_TAB[5'(i_q)]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      i_q    <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      flip_q <= flip;
      i_q    <= '0;
      x_q    <= erpt_pkg::CORDIC_X0;
      y_q    <= '0;
      z_q    <= z0;
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
      if (i_q == IW'(STAGES - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        i_q <= i_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Q30 -> Q16 with rounding, undo the half-turn fold
  assign xr = (x_q + 34'sd8192) >>> 14;
  assign yr = (y_q + 34'sd8192) >>> 14;
  assign cos_o  = erpt_pkg::sat18(40'(flip_q ? -xr : xr));
  assign sin_o  = erpt_pkg::sat18(40'(flip_q ? -yr : yr));
  assign done_o = done_q;
endmodule

/* rtl/erpt_xform.sv */
// ---------------------------------------------------------------------------
// erpt_xform: point datapath
// Four-stage pipeline: offset add, nine products, row sums, round/saturate.
// ---------------------------------------------------------------------------
module erpt_xform #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic                         inv_i,
  input  logic signed [17:0]           coef_i [9],
  input  logic signed [COORD_BITS:0]   off_i  [3],
  erpt_in_if.sink                      in_ch,
  erpt_out_if.source                   out_ch
);
  localparam int VW = COORD_BITS + 2;
  localparam int PW = VW + 18;
  localparam int SW = PW + 2;
  localparam int QW = SW - 16;
  localparam int DW = QW + 1;

  logic                  adv, acc;
  logic [3:0]            vld_q;
  logic signed [VW-1:0]  v_q [3];
  logic signed [PW-1:0]  p_q [9];
  logic signed [SW-1:0]  s_q [3];
  logic signed [COORD_BITS-1:0] o_q [3];
  logic signed [COORD_BITS-1:0] pin [3];
  logic signed [COORD_BITS-1:0] sat_w [3];

  // global advance: the whole pipe moves unless the output is held
  assign adv = !vld_q[3] || out_ch.ready;
  assign in_ch.ready = adv && go_i;
  assign acc = in_ch.valid && in_ch.ready;

  assign pin[0] = in_ch.in_x;
  assign pin[1] = in_ch.in_y;
  assign pin[2] = in_ch.in_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[2:0], acc};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      logic signed [QW-1:0] q;
      logic signed [DW-1:0] t;
      q = QW'(s_q[r] >>> 16);
      t = DW'(q) + (inv_i ? '0 : DW'(off_i[r]));
      if (t[DW-1:COORD_BITS-1] == '0 || t[DW-1:COORD_BITS-1] == '1)
        sat_w[r] = t[COORD_BITS-1:0];
      else
        sat_w[r] = {t[DW-1], {(COORD_BITS-1){~t[DW-1]}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++)
        v_q[c] <= VW'(pin[c]) + (inv_i ? VW'(off_i[c]) : '0);
      for (int k = 0; k < 9; k++)
        p_q[k] <= PW'(coef_i[k]) * PW'(v_q[k % 3]);
      for (int r = 0; r < 3; r++)
        s_q[r] <= SW'(p_q[3*r]) + SW'(p_q[3*r+1]) + SW'(p_q[3*r+2]) + SW'(32768);
      for (int r = 0; r < 3; r++)
        o_q[r] <= sat_w[r];
    end
  end

  assign out_ch.valid = vld_q[3];
  assign out_ch.out_x = o_q[0];
  assign out_ch.out_y = o_q[1];
  assign out_ch.out_z = o_q[2];
endmodule

/* rtl/euler_rigid_point_transform.sv */
// ---------------------------------------------------------------------------
// euler_rigid_point_transform: streaming rigid transform of 3-D points
// Rebuilds a rotation from Euler angles after configuration, then streams
// points through R*p + t or R^T*(p - t) with rounding and saturation.
// ---------------------------------------------------------------------------
// Usage:
//  - in_ch_i carries one point (Q16.16) per transaction, out_ch_o one result.
//  - cfg_we_i/cfg_idx_i/cfg_wdata_i write the registers (0..7); writes to
//    higher indexes are dropped. Write only while the stream is drained.
//  - Any register write starts a matrix rebuild: four CORDIC lanes run in
//    parallel, then one shared 21x18 multiplier walks the nine entries,
//    two terms each, two multiplies per term. in_ch_i.ready is low
//    meanwhile.
//  - Reset loads the default registers and runs the same rebuild before
//    the first point is taken.
//  - Streaming: one point per cycle while out_ch_o is not stalled, through
//    offset add, products, row sums and round/saturate, each registered.
//  - A receiver stall freezes the whole pipeline; the held result stays on
//    out_ch_o and in_ch_i.ready drops in the same cycle.
// ---------------------------------------------------------------------------
module euler_rigid_point_transform #(
  parameter int ANGLE_BITS    = 16,
  parameter int COORD_BITS    = 32,
  parameter int CORDIC_STAGES = 16,
  localparam int CfgW = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [3:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  erpt_in_if.sink         in_ch_i,
  erpt_out_if.source      out_ch_o
);
  localparam int OW = COORD_BITS + 1;

  typedef enum logic [2:0] {
    S_START, S_CORDIC, S_MUL, S_RND, S_FIN, S_READY
  } state_e;

  state_e state_q;

  // configuration registers
  logic [ANGLE_BITS-1:0] ang_q [4];
  logic [COORD_BITS-1:0] shift_q [3];
  logic [5:0]            mode_q;
  logic                  cfg_hit;

  // rebuild datapath
  logic signed [17:0]    coef_q [9];
  logic signed [OW-1:0]  off_q [3];
  logic                  inv_q;
  logic [3:0]            ent_q;
  logic                  trm_q, stp_q;
  logic signed [38:0]    prod_q;
  logic signed [20:0]    m_q;
  logic signed [21:0]    acc_q;

  logic                  cord_start;
  logic [3:0]            cord_done;
  logic                  all_done;
  logic signed [17:0]    cos_w [4];
  logic signed [17:0]    sin_w [4];
  logic signed [17:0]    trig_w [9];

  logic [3:0]            ord_sel;
  erpt_pkg::entry_t      ent_w;
  erpt_pkg::term_t       term_w;
  logic signed [20:0]    op_a;
  logic signed [17:0]    op_b;
  logic signed [38:0]    rsum;
  logic signed [20:0]    rnd;
  logic signed [21:0]    termv;
  logic signed [22:0]    tot;
  logic [3:0]            dst;

  assign cfg_hit    = cfg_we_i && (cfg_idx_i <= erpt_pkg::REG_MODE);
  assign cord_start = (state_q == S_START);
  assign all_done   = &cord_done;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    erpt_cordic #(
      .ANGLE_BITS (ANGLE_BITS),
      .STAGES     (CORDIC_STAGES)
    ) u_cordic (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (cord_start),
      .angle_i (ang_q[g]),
      .done_o  (cord_done[g]),
      .cos_o   (cos_w[g]),
      .sin_o   (sin_w[g])
    );
  end

  // operand table, indexed by operand code
  assign trig_w[erpt_pkg::OP_ONE] = erpt_pkg::ONE_Q16;
  assign trig_w[erpt_pkg::OP_CR]  = cos_w[0];
  assign trig_w[erpt_pkg::OP_SR]  = sin_w[0];
  assign trig_w[erpt_pkg::OP_CP]  = cos_w[1];
  assign trig_w[erpt_pkg::OP_SP]  = sin_w[1];
  assign trig_w[erpt_pkg::OP_CY]  = cos_w[2];
  assign trig_w[erpt_pkg::OP_SY]  = sin_w[2];
  assign trig_w[erpt_pkg::OP_CT]  = cos_w[3];
  assign trig_w[erpt_pkg::OP_ST]  = sin_w[3];

  // world frame and order codes 12..15 select the identity
  assign ord_sel = (mode_q[4] || mode_q[3:0] > erpt_pkg::ORD_YRP) ?
                   erpt_pkg::ORD_IDENT : mode_q[3:0];
  assign ent_w   = erpt_pkg::coef_term(ord_sel, ent_q);
  assign term_w  = trm_q ? ent_w.t1 : ent_w.t0;

  // first multiply of a term takes a*b, the second rnd(a*b)*c
  assign op_a = stp_q ? m_q : 21'(trig_w[term_w.a]);
  assign op_b = stp_q ? trig_w[term_w.c] : trig_w[term_w.b];

  assign rsum = prod_q + 39'sd32768;
  assign rnd  = 21'(rsum >>> 16);

  always_comb begin
    unique case (term_w.sg)
      erpt_pkg::SG_POS:  termv = 22'(rnd);
      erpt_pkg::SG_NEG:  termv = -22'(rnd);
      default:           termv = '0;
    endcase
  end

  assign tot = 23'(acc_q) + 23'(termv);

  // inverse stores R^T: entry (r,c) lands at (c,r)
  always_comb begin
    if (!mode_q[5]) begin
      dst = ent_q;
    end else begin
      unique case (ent_q)
        4'd1:    dst = 4'd3;
        4'd2:    dst = 4'd6;
        4'd3:    dst = 4'd1;
        4'd5:    dst = 4'd7;
        4'd6:    dst = 4'd2;
        4'd7:    dst = 4'd5;
        default: dst = ent_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START;
      for (int k = 0; k < 4; k++) ang_q[k] <= '0;
      for (int k = 0; k < 3; k++) shift_q[k] <= '0;
      mode_q  <= erpt_pkg::MODE_RESET;
      for (int k = 0; k < 9; k++)
        coef_q[k] <= (k % 4 == 0) ? erpt_pkg::ONE_Q16 : '0;
      for (int k = 0; k < 3; k++) off_q[k] <= '0;
      inv_q   <= 1'b0;
      ent_q   <= '0;
      trm_q   <= 1'b0;
      stp_q   <= 1'b0;
      prod_q  <= '0;
      m_q     <= '0;
      acc_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          erpt_pkg::REG_ROLL:  ang_q[0]   <= cfg_wdata_i[ANGLE_BITS-1:0];
          erpt_pkg::REG_PITCH: ang_q[1]   <= cfg_wdata_i[ANGLE_BITS-1:0];
          erpt_pkg::REG_YAW:   ang_q[2]   <= cfg_wdata_i[ANGLE_BITS-1:0];
          erpt_pkg::REG_THIRD: ang_q[3]   <= cfg_wdata_i[ANGLE_BITS-1:0];
          erpt_pkg::REG_SHX:   shift_q[0] <= cfg_wdata_i[COORD_BITS-1:0];
          erpt_pkg::REG_SHY:   shift_q[1] <= cfg_wdata_i[COORD_BITS-1:0];
          erpt_pkg::REG_SHZ:   shift_q[2] <= cfg_wdata_i[COORD_BITS-1:0];
          erpt_pkg::REG_MODE:  mode_q     <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        // any register write restarts the rebuild
        state_q <= S_START;
      end else begin
        unique case (state_q)
          S_START: begin
            ent_q   <= '0;
            trm_q   <= 1'b0;
            stp_q   <= 1'b0;
            acc_q   <= '0;
            state_q <= S_CORDIC;
          end
          S_CORDIC: begin
            if (all_done) state_q <= S_MUL;
          end
          S_MUL: begin
            prod_q  <= op_a * 39'(op_b);
            state_q <= S_RND;
          end
          S_RND: begin
            state_q <= S_MUL;
            if (!stp_q) begin
              m_q   <= rnd;
              stp_q <= 1'b1;
            end else if (!trm_q) begin
              acc_q <= termv;
              trm_q <= 1'b1;
              stp_q <= 1'b0;
            end else begin
              coef_q[dst] <= erpt_pkg::sat18(40'(tot));
              trm_q <= 1'b0;
              stp_q <= 1'b0;
              if (ent_q == 4'd8) state_q <= S_FIN;
              else ent_q <= ent_q + 4'd1;
            end
          end
          S_FIN: begin
            for (int k = 0; k < 3; k++)
              off_q[k] <= mode_q[5] ? -OW'(signed'(shift_q[k])) : OW'(signed'(shift_q[k]));
            inv_q   <= mode_q[5];
            state_q <= S_READY;
          end
          S_READY: ;
          default: state_q <= S_START;
        endcase
      end
    end
  end

  erpt_xform #(
    .COORD_BITS (COORD_BITS)
  ) u_xform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (state_q == S_READY),
    .inv_i  (inv_q),
    .coef_i (coef_q),
    .off_i  (off_q),
    .in_ch  (in_ch_i),
    .out_ch (out_ch_o)
  );
endmodule

/* rtl/erpt_checker.sv */
// ---------------------------------------------------------------------------
// erpt_checker: port-level checks of the rigid point transform
// Output channel rules, rebuild blocking after writes and after reset.
// ---------------------------------------------------------------------------
module erpt_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [3:0]            cfg_idx_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] out_x_i,
  input logic [COORD_BITS-1:0] out_y_i,
  input logic [COORD_BITS-1:0] out_z_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_y_i) && $stable(out_z_i))
    else $error("stalled result changed");

  // a register write must block the stream for the rebuild
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && !cfg_idx_i[3] |=> !in_ready_i ##1 !in_ready_i)
    else $error("point taken during rebuild");

  a_rst_block: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("point taken before first rebuild");
endmodule

bind euler_rigid_point_transform erpt_checker #(
  .COORD_BITS (COORD_BITS)
) u_erpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_x_i     (out_ch_o.out_x),
  .out_y_i     (out_ch_o.out_y),
  .out_z_i     (out_ch_o.out_z)
);
